// ===== rtl/quoted_list_parser_defines.svh =====
// assertion macros shared by the quoted list parser rtl
// expects clk_i and rst_ni in the module that uses them
`ifndef QUOTED_LIST_PARSER_DEFINES_SVH
`define QUOTED_LIST_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QLP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QLP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QLP_ASSERT(name, prop, msg)
`define QLP_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== rtl/qlp_pkg.sv =====
// types, character codes and result kinds for the quoted list parser
// no dependencies
`default_nettype none
package qlp_pkg;

  localparam int MAX_ELEMENTS = 255;
  localparam logic [7:0] TALLY_LIMIT =
    (MAX_ELEMENTS > 255) ? 8'd255 : 8'(MAX_ELEMENTS);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] element_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/qlp_in_reg.sv =====
// input register stage: holds one character transaction for the parser
// depends on qlp_pkg
`default_nettype none
module qlp_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    char_byte_i,
  input  wire logic          last_char_i,
  input  wire logic          advance_i,
  output logic               in_stall_o,
  output logic               valid_o,
  output qlp_pkg::item_t     item_o
);

  logic           valid_q, valid_d;
  qlp_pkg::item_t item_q;
  logic           load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.char_byte <= char_byte_i;
      item_q.last_char <= last_char_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== rtl/qlp_parse.sv =====
// parse state machine: phase and element tally, one character per advance
// depends on qlp_pkg and quoted_list_parser_defines.svh
`default_nettype none
`include "quoted_list_parser_defines.svh"
module qlp_parse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire qlp_pkg::item_t item_i,
  output qlp_pkg::result_t   result_o
);

  localparam logic [2:0] PH_BEFORE_OPEN  = 3'd0;
  localparam logic [2:0] PH_EXPECT_FIRST = 3'd1;
  localparam logic [2:0] PH_IN_QUOTE     = 3'd2;
  localparam logic [2:0] PH_ESCAPE       = 3'd3;
  localparam logic [2:0] PH_AFTER_ELEM   = 3'd4;
  localparam logic [2:0] PH_AFTER_COMMA  = 3'd5;
  localparam logic [2:0] PH_AFTER_CLOSE  = 3'd6;
  localparam logic [2:0] PH_ERROR        = 3'd7;

  logic [2:0] phase_q, phase_d;
  logic [7:0] tally_q, tally_d;
  logic [2:0] next_ph;
  logic [7:0] tally_step;
  logic       emit_byte, emit_end;
  logic [7:0] c;

  assign c = item_i.char_byte;

  always_comb begin
    next_ph    = PH_ERROR;
    tally_step = tally_q;
    emit_byte  = 1'b0;
    emit_end   = 1'b0;
    unique case (phase_q)
      PH_BEFORE_OPEN: begin
        if (c == qlp_pkg::CH_SPACE) next_ph = phase_q;
        else if (c == qlp_pkg::CH_OPEN) next_ph = PH_EXPECT_FIRST;
      end
      PH_EXPECT_FIRST, PH_AFTER_COMMA: begin
        if (c == qlp_pkg::CH_SPACE) next_ph = phase_q;
        else if (c == qlp_pkg::CH_QUOTE) next_ph = PH_IN_QUOTE;
      end
      PH_IN_QUOTE: begin
        if (c == qlp_pkg::CH_BSLASH) begin
          next_ph = PH_ESCAPE;
        end else if (c == qlp_pkg::CH_QUOTE) begin
          if (tally_q < qlp_pkg::TALLY_LIMIT) begin
            tally_step = tally_q + 8'd1;
            next_ph    = PH_AFTER_ELEM;
            emit_end   = 1'b1;
          end
        end else begin
          next_ph   = PH_IN_QUOTE;
          emit_byte = 1'b1;
        end
      end
      PH_ESCAPE: begin
        if (c == qlp_pkg::CH_BSLASH || c == qlp_pkg::CH_QUOTE) begin
          next_ph   = PH_IN_QUOTE;
          emit_byte = 1'b1;
        end
      end
      PH_AFTER_ELEM: begin
        if (c == qlp_pkg::CH_SPACE) next_ph = phase_q;
        else if (c == qlp_pkg::CH_COMMA) next_ph = PH_AFTER_COMMA;
        else if (c == qlp_pkg::CH_CLOSE) next_ph = PH_AFTER_CLOSE;
      end
      PH_AFTER_CLOSE: begin
        if (c == qlp_pkg::CH_SPACE) next_ph = phase_q;
      end
      PH_ERROR: begin
        next_ph = PH_ERROR;
      end
      default: begin
        next_ph = PH_ERROR;
      end
    endcase
  end

  always_comb begin
    result_o.element_count = tally_step;
    result_o.data_byte     = 8'd0;
    result_o.kind          = qlp_pkg::KIND_BYTE;
    result_o.valid         = 1'b0;
    phase_d                = phase_q;
    tally_d                = tally_q;
    if (advance_i) begin
      if (item_i.last_char) begin
        result_o.valid = 1'b1;
        result_o.kind  = (next_ph == PH_AFTER_CLOSE) ? qlp_pkg::KIND_OK
                                                     : qlp_pkg::KIND_ERR;
        phase_d        = PH_BEFORE_OPEN;
        tally_d        = 8'd0;
      end else begin
        phase_d = next_ph;
        tally_d = tally_step;
        if (emit_byte) begin
          result_o.valid     = 1'b1;
          result_o.kind      = qlp_pkg::KIND_BYTE;
          result_o.data_byte = c;
        end else if (emit_end) begin
          result_o.valid = 1'b1;
          result_o.kind  = qlp_pkg::KIND_END;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEFORE_OPEN;
      tally_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      tally_q <= tally_d;
    end
  end

  `QLP_ASSERT(a_final_restarts, advance_i && item_i.last_char |=> phase_q == PH_BEFORE_OPEN && tally_q == 8'd0, "final result did not return parser to idle")
  `QLP_ASSERT(a_tally_bounded, tally_q <= qlp_pkg::TALLY_LIMIT, "element tally beyond limit")
  `QLP_ASSERT(a_end_counts, result_o.valid && result_o.kind == qlp_pkg::KIND_END |=> tally_q == $past(tally_q) + 8'd1, "element end without tally increment")
  `QLP_ASSERT(a_error_sticks, advance_i && !item_i.last_char && phase_q == PH_ERROR |=> phase_q == PH_ERROR, "left error phase before end mark")

endmodule
`default_nettype wire

// ===== rtl/qlp_out_reg.sv =====
// result register stage: holds one result transaction until taken
// depends on qlp_pkg
`default_nettype none
module qlp_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire qlp_pkg::result_t result_i,
  input  wire logic          out_stall_i,
  output logic               free_o,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [7:0]         element_count_o
);

  logic       valid_q, valid_d;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic [7:0] count_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      kind_q  <= result_i.kind;
      data_q  <= result_i.data_byte;
      count_q <= result_i.element_count;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign element_count_o = count_q;

endmodule
`default_nettype wire

// ===== rtl/quoted_list_parser.sv =====
// Quoted list parser: checks and unescapes text like { "a" , "b\"c" }, one
// character per transaction, with last_char_i on the final character. Each
// element byte comes out unescaped (kind 0), a closing quote gives an element
// end (kind 1), and the final character gives ok (2) or error (3) with the
// element count; after an error input is dropped until the end mark. A
// character is taken every cycle unless out_stall_i backs up: it passes an
// input register, the parse state machine and a result register in that
// order, and the only stall comes from out_stall_i backing up.
// depends on qlp_pkg, qlp_in_reg, qlp_parse, qlp_out_reg
`default_nettype none
module quoted_list_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       last_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      element_count_o
);

  qlp_pkg::item_t   item;
  qlp_pkg::result_t result;
  logic             item_valid;
  logic             out_free;
  logic             advance;

  assign advance = item_valid && out_free;

  qlp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .char_byte_i (char_byte_i),
    .last_char_i (last_char_i),
    .advance_i   (advance),
    .in_stall_o  (in_stall_o),
    .valid_o     (item_valid),
    .item_o      (item)
  );

  qlp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  qlp_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .result_i        (result),
    .out_stall_i     (out_stall_i),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .element_count_o (element_count_o)
  );

endmodule
`default_nettype wire
